// ===== rtl/best_fit_slot_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit slot allocator
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define BEST_FIT_SLOT_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BFSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared codes, widths and the table control bundle of the slot allocator.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int AGE_W    = 16;
  localparam int STRIDE_W = 11;
  localparam int ADDR_W   = 64;
  localparam int COUNT_W  = 9;
  localparam int SLOT_W   = 8;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic REG_HEAP_BASE   = 1'b0;
  localparam logic REG_SLOT_STRIDE = 1'b1;

  localparam logic [STRIDE_W-1:0] STRIDE_RST = 11'd32;

  typedef struct packed {
    logic rd_en;
    logic we;
    logic set_valid;
    logic clr_en;
  } tbl_ctl_t;

endpackage

// ===== rtl/bfsa_table.sv =====
// ----------------------------------------------------------------------------
// bfsa_table
// Free-block table: one-port-read / one-port-write synchronous memory with
// registered read data, per-entry valid flops and a reset image for entry 0.
// ----------------------------------------------------------------------------
module bfsa_table #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 33,
  parameter logic [DW-1:0] INIT0 = '0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bfsa_pkg::tbl_ctl_t ctl,
  input  logic [AW-1:0]   rd_addr,
  input  logic [AW-1:0]   wr_addr,
  input  logic [DW-1:0]   wr_data,
  input  logic [AW-1:0]   clr_addr,
  output logic [DW-1:0]   rd_data,
  output logic            rd_valid
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic             e0_fresh_r;
  logic [DW-1:0]    mem_q_r;
  logic             use_init_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= DEPTH'(1);
      e0_fresh_r <= 1'b1;
      use_init_r <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.rd_en) begin
        use_init_r <= e0_fresh_r && (rd_addr == '0);
        rd_valid_r <= valid_r[rd_addr];
      end
      if (ctl.clr_en) begin
        valid_r[clr_addr] <= 1'b0;
      end
      if (ctl.we) begin
        valid_r[wr_addr] <= ctl.set_valid;
        if (wr_addr == '0) begin
          e0_fresh_r <= 1'b0;
        end
      end
    end
  end

  assign rd_data  = use_init_r ? INIT0 : mem_q_r;
  assign rd_valid = rd_valid_r;

endmodule

// ===== rtl/bfsa_addr.sv =====
// ----------------------------------------------------------------------------
// bfsa_addr
// Slot address unit: registered slot * stride product, then base add.
// ----------------------------------------------------------------------------
module bfsa_addr #(
  parameter int SW = 8
) (
  input  logic                               clk,
  input  logic                               mul_en,
  input  logic [SW-1:0]                      slot_idx,
  input  logic [bfsa_pkg::STRIDE_W-1:0]      stride,
  input  logic [bfsa_pkg::ADDR_W-1:0]        base,
  input  logic                               grant,
  output logic [bfsa_pkg::ADDR_W-1:0]        addr
);

  localparam int PW = SW + bfsa_pkg::STRIDE_W;

  logic [PW-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PW'(slot_idx) * PW'(stride);
    end
  end

  assign addr = grant ? (base + bfsa_pkg::ADDR_W'(prod_r)) : '0;

endmodule

// ===== rtl/best_fit_slot_allocator_top.sv =====
// Flow: a request that scans the table passes through S_SCAN, S_COMMIT, S_MUL
//   and S_FIN; a zero count or bad slot goes straight to S_MUL and S_FIN.
// One request is in flight at a time (in_ready only in S_IDLE); the scan
//   reads one entry per cycle through the single memory read port.
// Reset: synchronous, active low; entry 0 reads as one block covering the
//   whole page until first written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// best_fit_slot_allocator_top
// Best-fit free-block allocator with coalescing on free, over a table of
// free blocks held in a synchronous memory and scanned per request.
// ----------------------------------------------------------------------------
`include "best_fit_slot_allocator_top_macros.svh"

module best_fit_slot_allocator_top #(
  parameter int SLOTS      = 256,
  parameter int MAX_BLOCKS = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [bfsa_pkg::ADDR_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic [bfsa_pkg::COUNT_W-1:0]      in_count,
  input  logic [bfsa_pkg::SLOT_W-1:0]       in_slot,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [bfsa_pkg::SLOT_W-1:0]       out_first_slot,
  output logic [bfsa_pkg::ADDR_W-1:0]       out_first_address
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int XW = ((LW > 9) ? LW : 9) + 1;
  localparam int AGW = bfsa_pkg::AGE_W;
  localparam int DW = SW + LW + AGW;
  localparam logic [DW-1:0] INIT0 = {SW'(0), LW'(SLOTS), AGW'(0)};

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_COMMIT, S_MUL, S_FIN} state_t;

  state_t state_r;

  logic [bfsa_pkg::ADDR_W-1:0]   base_r;
  logic [bfsa_pkg::STRIDE_W-1:0] stride_r;

  logic                          mode_r;
  logic [bfsa_pkg::COUNT_W-1:0]  count_r;
  logic [bfsa_pkg::SLOT_W-1:0]   slot_r;
  logic [AGW-1:0]                ctr_r, ctr_nxt;

  logic [CW-1:0] issue_r;
  logic          pend_r;
  logic [IW-1:0] pidx_r;

  logic          found_r;
  logic [IW-1:0] best_idx_r;
  logic [SW-1:0] best_start_r;
  logic [LW-1:0] best_len_r;
  logic [AGW-1:0] best_dist_r;

  logic          dup_r, left_r, right_r, spare_r;
  logic [IW-1:0] left_idx_r, right_idx_r, spare_idx_r;
  logic [SW-1:0] left_start_r;
  logic [LW-1:0] left_len_r, right_len_r;

  logic [1:0]    res_status_r;
  logic [SW-1:0] res_start_r;
  logic          res_grant_r;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [bfsa_pkg::SLOT_W-1:0] out_slot_r;
  logic [bfsa_pkg::ADDR_W-1:0] out_addr_r;

  bfsa_pkg::tbl_ctl_t tctl;
  logic [IW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic [DW-1:0] rd_data;
  logic          rd_valid;
  logic [bfsa_pkg::ADDR_W-1:0] addr;

  logic          issuing;
  logic [SW-1:0] e_start;
  logic [LW-1:0] e_len;
  logic [AGW-1:0] e_age;
  logic [AGW-1:0] e_dist;
  logic [XW-1:0] x_start, x_len, x_slot, x_count;
  logic          fits, better, covers, is_left, is_right;

  logic [LW-1:0] new_len;
  logic [XW-1:0] m_start, m_len;
  logic          acc_in, fin_go;

  assign in_ready = (state_r == S_IDLE);
  assign acc_in   = in_valid && in_ready;
  assign fin_go   = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign issuing  = (state_r == S_SCAN) && (issue_r < CW'(MAX_BLOCKS));

  assign {e_start, e_len, e_age} = rd_data;
  assign e_dist  = ctr_r - e_age;
  assign x_start = XW'(e_start);
  assign x_len   = XW'(e_len);
  assign x_slot  = XW'(slot_r);
  assign x_count = XW'(count_r);
  assign fits    = rd_valid && (x_len >= x_count);
  assign better  = !found_r || (e_len < best_len_r) ||
                   ((e_len == best_len_r) && (e_dist > best_dist_r));
  assign covers  = (x_slot >= x_start) && ((x_slot - x_start) < x_len);
  assign is_left  = (x_start + x_len) == x_slot;
  assign is_right = x_start == (x_slot + XW'(1));

  assign new_len = best_len_r - LW'(count_r);
  assign m_start = left_r ? XW'(left_start_r) : x_slot;
  assign m_len   = XW'(1) + (left_r ? XW'(left_len_r) : '0) +
                   (right_r ? XW'(right_len_r) : '0);
  assign ctr_nxt = ctr_r + AGW'(1);

  always_comb begin
    tctl    = '0;
    wr_addr = best_idx_r;
    wr_data = {best_start_r + SW'(count_r), new_len, ctr_r};
    tctl.rd_en = issuing;
    if (state_r == S_COMMIT) begin
      if (mode_r == bfsa_pkg::MODE_ALLOC) begin
        if (found_r) begin
          tctl.we        = 1'b1;
          tctl.set_valid = (new_len != '0);
        end
      end else if (!dup_r && (left_r || right_r || spare_r)) begin
        tctl.we        = 1'b1;
        tctl.set_valid = 1'b1;
        tctl.clr_en    = left_r && right_r;
        wr_addr = left_r ? left_idx_r : (right_r ? right_idx_r : spare_idx_r);
        wr_data = {m_start[SW-1:0], m_len[LW-1:0], ctr_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      stride_r <= bfsa_pkg::STRIDE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bfsa_pkg::REG_HEAP_BASE:   base_r   <= cfg_wdata;
        bfsa_pkg::REG_SLOT_STRIDE: stride_r <= cfg_wdata[bfsa_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctr_r       <= AGW'(1);
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      issue_r     <= '0;
    end else begin
      if (out_valid_r && out_ready && !fin_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc_in) begin
            mode_r  <= in_mode;
            count_r <= in_count;
            slot_r  <= in_slot;
            found_r <= 1'b0;
            dup_r   <= 1'b0;
            left_r  <= 1'b0;
            right_r <= 1'b0;
            spare_r <= 1'b0;
            issue_r <= '0;
            pend_r  <= 1'b0;
            res_grant_r  <= 1'b0;
            res_start_r  <= '0;
            res_status_r <= bfsa_pkg::ST_BAD;
            if ((in_mode == bfsa_pkg::MODE_ALLOC && in_count == '0) ||
                (in_mode == bfsa_pkg::MODE_FREE && XW'(in_slot) >= XW'(SLOTS))) begin
              state_r <= S_MUL;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pend_r <= issuing;
          pidx_r <= issue_r[IW-1:0];
          if (issuing) begin
            issue_r <= issue_r + CW'(1);
          end
          if (pend_r) begin
            if (mode_r == bfsa_pkg::MODE_ALLOC) begin
              if (fits && better) begin
                found_r      <= 1'b1;
                best_idx_r   <= pidx_r;
                best_start_r <= e_start;
                best_len_r   <= e_len;
                best_dist_r  <= e_dist;
              end
            end else if (!rd_valid) begin
              if (!spare_r) begin
                spare_r     <= 1'b1;
                spare_idx_r <= pidx_r;
              end
            end else begin
              if (covers) begin
                dup_r <= 1'b1;
              end
              if (is_left) begin
                left_r       <= 1'b1;
                left_idx_r   <= pidx_r;
                left_start_r <= e_start;
                left_len_r   <= e_len;
              end
              if (is_right) begin
                right_r     <= 1'b1;
                right_idx_r <= pidx_r;
                right_len_r <= e_len;
              end
            end
          end
          if (!issuing && !pend_r) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          state_r <= S_MUL;
          if (mode_r == bfsa_pkg::MODE_ALLOC) begin
            if (found_r) begin
              res_status_r <= bfsa_pkg::ST_DONE;
              res_start_r  <= best_start_r;
              res_grant_r  <= 1'b1;
              if (new_len != '0) begin
                ctr_r <= ctr_nxt;
              end
            end else begin
              res_status_r <= bfsa_pkg::ST_NOSPACE;
            end
          end else if (dup_r) begin
            res_status_r <= bfsa_pkg::ST_BAD;
          end else if (left_r || right_r || spare_r) begin
            res_status_r <= bfsa_pkg::ST_DONE;
            ctr_r        <= ctr_nxt;
          end else begin
            res_status_r <= bfsa_pkg::ST_NOSPACE;
          end
        end
        S_MUL: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= res_grant_r ? bfsa_pkg::SLOT_W'(XW'(res_start_r)) : '0;
            out_addr_r   <= addr;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  bfsa_table #(
    .DEPTH (MAX_BLOCKS),
    .AW    (IW),
    .DW    (DW),
    .INIT0 (INIT0)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (tctl),
    .rd_addr  (issue_r[IW-1:0]),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clr_addr (right_idx_r),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  bfsa_addr #(
    .SW (SW)
  ) u_addr (
    .clk      (clk),
    .mul_en   (state_r == S_MUL),
    .slot_idx (res_start_r),
    .stride   (stride_r),
    .base     (base_r),
    .grant    (res_grant_r),
    .addr     (addr)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_first_slot    = out_slot_r;
  assign out_first_address = out_addr_r;

  `BFSA_ASSERT_NEXT(a_one_in_flight, acc_in, !in_ready, "request accepted while busy")
  `BFSA_ASSERT_NOW(a_write_in_commit, tctl.we, state_r == S_COMMIT, "table write outside commit")
  `BFSA_ASSERT_NOW(a_no_grant_zero, out_valid_r && (out_status_r != bfsa_pkg::ST_DONE),
                   (out_addr_r == '0) && (out_slot_r == '0), "failed request returned address")
  `BFSA_ASSERT_NOW(a_scan_no_write, state_r == S_SCAN, !tctl.we && !tctl.clr_en,
                   "table modified during scan")

endmodule

// ===== tb/tb_best_fit_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Best-fit slot allocator testbench
// Drives allocate and free requests with random gaps and result stalls,
// predicts every result from a shadow free-block table, and compares each
// result field by field. Base and stride are changed between idle phases.
// ----------------------------------------------------------------------------
module tb_best_fit_slot_allocator_top;

  localparam int NSLOTS   = 256;
  localparam int NBLOCKS  = 128;
  localparam int SETTLE   = NBLOCKS + 12;
  localparam int WD_LIMIT = 4000;

  localparam int COUNT_W  = bfsa_pkg::COUNT_W;
  localparam int SLOT_W   = bfsa_pkg::SLOT_W;
  localparam int ADDR_W   = bfsa_pkg::ADDR_W;
  localparam int AGE_W    = bfsa_pkg::AGE_W;
  localparam int STRIDE_W = bfsa_pkg::STRIDE_W;

  typedef struct packed {
    logic               mode;
    logic [COUNT_W-1:0] count;
    logic [SLOT_W-1:0]  slot;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] first_slot;
    logic [ADDR_W-1:0] first_address;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = bfsa_pkg::REG_HEAP_BASE;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = bfsa_pkg::MODE_ALLOC;
  logic [COUNT_W-1:0] in_count = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [SLOT_W-1:0] out_first_slot;
  logic [ADDR_W-1:0] out_first_address;

  best_fit_slot_allocator_top dut (.*);

  always #4 clk = ~clk;

  // shadow free-block table
  logic [SLOT_W:0]     blk_start [NBLOCKS];
  logic [COUNT_W-1:0]  blk_len   [NBLOCKS];
  logic                blk_used  [NBLOCKS];
  logic [AGE_W-1:0]    blk_age   [NBLOCKS];
  logic [AGE_W-1:0]    age_ctr;
  logic [ADDR_W-1:0]   base_q;
  logic [STRIDE_W-1:0] stride_q;

  alloc_req_t pending_reqs[$];
  grant_t     expected_grants[$];
  int errors = 0;
  bit no_gaps = 0;
  bit in_fire = 0, out_fire = 0;
  int in_gap = 0, out_wait = 0, idle_cycles = 0;

  function automatic grant_t make_grant(logic [1:0] st, logic [SLOT_W:0] first,
                                        bit granted);
    grant_t g;
    g.status = st;
    g.first_slot = granted ? first[SLOT_W-1:0] : '0;
    g.first_address = granted ? base_q + ADDR_W'(first) * ADDR_W'(stride_q) : '0;
    return g;
  endfunction

  function automatic grant_t allocate_slots(logic [COUNT_W-1:0] cnt);
    int best;
    logic [COUNT_W-1:0] best_len;
    logic [AGE_W-1:0] best_gap, age_gap;
    logic [SLOT_W:0] first;
    best = -1;
    best_len = '0;
    best_gap = '0;
    if (cnt == '0) return make_grant(bfsa_pkg::ST_BAD, '0, 0);
    for (int i = 0; i < NBLOCKS; i++) begin
      if (!blk_used[i] || blk_len[i] < cnt) continue;
      age_gap = age_ctr - blk_age[i];
      if (best < 0 || blk_len[i] < best_len ||
          (blk_len[i] == best_len && age_gap > best_gap)) begin
        best = i;
        best_len = blk_len[i];
        best_gap = age_gap;
      end
    end
    if (best < 0) return make_grant(bfsa_pkg::ST_NOSPACE, '0, 0);
    first = blk_start[best];
    blk_len[best] = blk_len[best] - cnt;
    if (blk_len[best] == '0) begin
      blk_used[best] = 1'b0;
      blk_start[best] = '0;
      blk_age[best] = '0;
    end else begin
      blk_start[best] = blk_start[best] + (SLOT_W+1)'(cnt);
      blk_age[best] = age_ctr;
      age_ctr++;
    end
    return make_grant(bfsa_pkg::ST_DONE, first, 1);
  endfunction

  function automatic grant_t release_slot(logic [SLOT_W-1:0] s);
    int left, right, spare, tgt;
    logic [SLOT_W:0] st;
    logic [COUNT_W-1:0] len;
    left = -1;
    right = -1;
    spare = -1;
    st = (SLOT_W+1)'(s);
    len = COUNT_W'(1);
    for (int i = 0; i < NBLOCKS; i++) begin
      if (!blk_used[i]) begin
        if (spare < 0) spare = i;
        continue;
      end
      if (s >= blk_start[i] && s - blk_start[i] < blk_len[i])
        return make_grant(bfsa_pkg::ST_BAD, '0, 0);
      if (blk_start[i] + blk_len[i] == s) left = i;
      if (blk_start[i] == s + 1) right = i;
    end
    if (left >= 0) begin
      st = blk_start[left];
      len = len + blk_len[left];
    end
    if (right >= 0) len = len + blk_len[right];
    tgt = (left >= 0) ? left : (right >= 0) ? right : spare;
    if (tgt < 0) return make_grant(bfsa_pkg::ST_NOSPACE, '0, 0);
    if (left >= 0 && right >= 0) begin
      blk_used[right] = 1'b0;
      blk_start[right] = '0;
      blk_len[right] = '0;
      blk_age[right] = '0;
    end
    blk_used[tgt] = 1'b1;
    blk_start[tgt] = st;
    blk_len[tgt] = len;
    blk_age[tgt] = age_ctr;
    age_ctr++;
    return make_grant(bfsa_pkg::ST_DONE, '0, 0);
  endfunction

  // accept detection, prediction and result checking
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    if (in_fire)
      expected_grants.push_back(in_mode == bfsa_pkg::MODE_ALLOC ? allocate_slots(in_count)
                                                                : release_slot(in_slot));
    if (out_fire) begin
      if (expected_grants.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        grant_t e;
        e = expected_grants.pop_front();
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status);
          errors++;
        end
        if (out_first_slot !== e.first_slot) begin
          $error("first_slot exp %0d got %0d", e.first_slot, out_first_slot);
          errors++;
        end
        if (out_first_address !== e.first_address) begin
          $error("first_address exp %h got %h", e.first_address, out_first_address);
          errors++;
        end
      end
    end
    idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("FAIL best_fit_slot_allocator_top");
      $finish;
    end
  end

  // request driver
  always @(negedge clk) begin
    alloc_req_t r;
    logic nxt_valid;
    nxt_valid = in_valid && !in_fire;
    if (rst_n && !nxt_valid) begin
      if (in_gap > 0) in_gap--;
      else if (pending_reqs.size() != 0) begin
        r = pending_reqs.pop_front();
        in_mode <= r.mode;
        in_count <= r.count;
        in_slot <= r.slot;
        nxt_valid = 1'b1;
        in_gap = no_gaps ? 0 : $urandom_range(0, 9);
      end
    end
    in_valid <= nxt_valid;
  end

  // result stalls
  always @(negedge clk) begin
    if (out_fire) out_wait = no_gaps ? 0 : $urandom_range(0, 9);
    if (out_wait > 0) begin
      out_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
    end
  end

  task automatic push_req(logic m, int cnt, int s);
    alloc_req_t r;
    r.mode = m;
    r.count = COUNT_W'(cnt);
    r.slot = SLOT_W'(s);
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_grants.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bfsa_pkg::REG_HEAP_BASE) base_q = val;
    else stride_q = val[STRIDE_W-1:0];
  endtask

  task automatic push_random(int n);
    int p;
    repeat (n) begin
      p = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 55) begin
        if (p < 70) push_req(bfsa_pkg::MODE_ALLOC, $urandom_range(1, 4), $urandom);
        else if (p < 90) push_req(bfsa_pkg::MODE_ALLOC, $urandom_range(5, 32), $urandom);
        else if (p < 98) push_req(bfsa_pkg::MODE_ALLOC, $urandom_range(33, 256), $urandom);
        else push_req(bfsa_pkg::MODE_ALLOC, $urandom_range(0, 511), $urandom);
      end else begin
        push_req(bfsa_pkg::MODE_FREE, $urandom, $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] bases [4];
    logic [STRIDE_W-1:0] strides [4];
    for (int i = 0; i < NBLOCKS; i++) begin
      blk_start[i] = '0;
      blk_len[i] = '0;
      blk_used[i] = 1'b0;
      blk_age[i] = '0;
    end
    blk_used[0] = 1'b1;
    blk_len[0] = COUNT_W'(NSLOTS);
    age_ctr = AGE_W'(1);
    base_q = '0;
    stride_q = bfsa_pkg::STRIDE_RST;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset values of the registers
    push_req(bfsa_pkg::MODE_ALLOC, 0, 0);
    push_req(bfsa_pkg::MODE_ALLOC, 256, 0);
    push_req(bfsa_pkg::MODE_ALLOC, 1, 0);
    push_req(bfsa_pkg::MODE_FREE, 0, 255);
    push_req(bfsa_pkg::MODE_FREE, 0, 255);
    push_req(bfsa_pkg::MODE_FREE, 0, 0);
    push_req(bfsa_pkg::MODE_FREE, 0, 1);
    push_req(bfsa_pkg::MODE_FREE, 0, 254);
    push_req(bfsa_pkg::MODE_FREE, 0, 128);
    push_req(bfsa_pkg::MODE_FREE, 0, 130);
    push_req(bfsa_pkg::MODE_ALLOC, 1, 0);
    push_req(bfsa_pkg::MODE_ALLOC, 2, 0);
    push_req(bfsa_pkg::MODE_ALLOC, 511, 0);
    push_req(bfsa_pkg::MODE_ALLOC, 1, 0);
    push_req(bfsa_pkg::MODE_FREE, 0, 129);
    push_req(bfsa_pkg::MODE_ALLOC, 3, 0);
    drain();

    write_reg(bfsa_pkg::REG_HEAP_BASE, '1);
    write_reg(bfsa_pkg::REG_SLOT_STRIDE, ADDR_W'(1024));
    // fragment the page into equal-size blocks to exercise age ordering
    for (int s = 0; s < NSLOTS; s++) push_req(bfsa_pkg::MODE_FREE, 0, s);
    push_req(bfsa_pkg::MODE_ALLOC, 256, 0);
    for (int s = 0; s < NSLOTS; s += 2) push_req(bfsa_pkg::MODE_FREE, 0, s);
    for (int k = 0; k < 40; k++) push_req(bfsa_pkg::MODE_ALLOC, 1, 0);
    drain();

    bases = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h0};
    strides = '{11'd1, 11'd0, 11'h7FF, 11'd32};
    for (int ph = 0; ph < 8; ph++) begin
      bases[3] = {$urandom, $urandom};
      write_reg(bfsa_pkg::REG_HEAP_BASE, bases[ph % 4]);
      write_reg(bfsa_pkg::REG_SLOT_STRIDE, ph == 7 ? ADDR_W'($urandom_range(1, 1024))
                                                   : ADDR_W'(strides[ph % 4]));
      no_gaps = (ph % 3 == 2);
      push_random(170);
      drain();
    end

    if (errors == 0) $display("PASS best_fit_slot_allocator_top");
    else $display("FAIL best_fit_slot_allocator_top");
    $finish;
  end
endmodule
